### rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// Used by ple_ctrl, ple_dp and positional_list_engine_core; no dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef enum logic [2:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_POS   = 3'd1,
		ACT_INS_BACK  = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_POS   = 3'd4,
		ACT_DEL_BACK  = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;        // capture request transaction
		logic decode;       // check request, set target and pointer
		logic rd_ins;       // read entry below the pointer
		logic rd_del_next;  // read entry above the pointer
		logic wr_shift;     // write read data at the pointer
		logic wr_put;       // write new value at the target
		logic del_cap;      // capture the removed value
		logic idx_dec;
		logic idx_inc;
		logic cnt_inc;
		logic cnt_dec;
		logic load_rsp;     // move result into the output register
	} ple_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic go_ins;
		logic go_del;
		logic ins_more;
		logic del_more;
		logic rsp_free;
	} ple_sts_t;

endpackage

### rtl/ple_ctrl.sv
// Sequencing state machine for the positional list engine.
// Depends on ple_pkg for the command and status structs.
`timescale 1ns / 1ps

module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ple_pkg::ple_sts_t sts,
	output ple_pkg::ple_cmd_t cmd
);
	import ple_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_DECODE  = 10'b00_0000_0010,
		S_INS_RD  = 10'b00_0000_0100,
		S_INS_WR  = 10'b00_0000_1000,
		S_INS_PUT = 10'b00_0001_0000,
		S_DEL_RD  = 10'b00_0010_0000,
		S_DEL_CAP = 10'b00_0100_0000,
		S_DEL_MRD = 10'b00_1000_0000,
		S_DEL_MWR = 10'b01_0000_0000,
		S_FINISH  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.go_ins) begin
					state_d = S_INS_RD;
				end else if (sts.go_del) begin
					state_d = S_DEL_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_INS_RD: begin
				cmd.rd_ins = 1'b1;
				state_d    = sts.ins_more ? S_INS_WR : S_INS_PUT;
			end
			S_INS_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dec  = 1'b1;
				state_d      = S_INS_RD;
			end
			S_INS_PUT: begin
				cmd.wr_put  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = S_FINISH;
			end
			S_DEL_RD: begin
				state_d = S_DEL_CAP;
			end
			S_DEL_CAP: begin
				cmd.del_cap = 1'b1;
				state_d     = S_DEL_MRD;
			end
			S_DEL_MRD: begin
				cmd.rd_del_next = 1'b1;
				if (sts.del_more) begin
					state_d = S_DEL_MWR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_DEL_MWR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_DEL_MRD;
			end
			S_FINISH: begin
				// hold until the output register can take the result
				if (sts.rsp_free) begin
					cmd.load_rsp = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/ple_dp.sv
// Datapath for the positional list engine: entry memory, fill count,
// shift pointer and output register. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_dp #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ple_pkg::ple_cmd_t  cmd,
	output ple_pkg::ple_sts_t  sts,
	input  logic [2:0]         action,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [31:0] removed_value,
	output logic [1:0]         status,
	output logic [6:0]         element_count
);
	import ple_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;

	logic [31:0]   mem [CAPACITY];
	logic [31:0]   rd_q;
	logic [2:0]    action_q;
	logic [6:0]    pos_q;
	logic [31:0]   value_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] tgt_q;
	logic [31:0]   removed_q;
	status_t       status_q;
	logic          rsp_valid_q;
	logic [31:0]   rsp_removed_q;
	logic [1:0]    rsp_status_q;
	logic [6:0]    rsp_count_q;

	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic          full;
	logic          empty;
	status_t       dec_status;
	logic          dec_ins;
	logic          dec_del;
	logic [CW-1:0] dec_tgt;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] idx_p1;
	logic [CW:0]   idx_p1_wide;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic          we;

	assign pos_ext = PW'(pos_q);
	assign cnt_ext = PW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);

	always_comb begin
		dec_status = ST_OK;
		dec_ins    = 1'b0;
		dec_del    = 1'b0;
		dec_tgt    = '0;
		case (action_q)
			ACT_INS_FRONT: begin
				dec_ins = 1'b1;
				if (full) dec_status = ST_FULL;
			end
			ACT_INS_POS: begin
				dec_ins = 1'b1;
				dec_tgt = pos_ext[CW-1:0];
				if (pos_ext > cnt_ext) begin
					dec_status = ST_BAD_POS;
				end else if (full) begin
					dec_status = ST_FULL;
				end
			end
			ACT_INS_BACK: begin
				dec_ins = 1'b1;
				dec_tgt = count_q;
				if (full) dec_status = ST_FULL;
			end
			ACT_DEL_FRONT: begin
				dec_del = 1'b1;
				if (empty) dec_status = ST_EMPTY;
			end
			ACT_DEL_POS: begin
				dec_del = 1'b1;
				dec_tgt = pos_ext[CW-1:0];
				if (pos_ext >= cnt_ext) dec_status = ST_BAD_POS;
			end
			ACT_DEL_BACK: begin
				dec_del = 1'b1;
				dec_tgt = count_q - CW'(1);
				if (empty) dec_status = ST_EMPTY;
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	assign idx_m1      = idx_q - CW'(1);
	assign idx_p1_wide = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_p1      = idx_p1_wide[CW-1:0];

	assign sts.go_ins   = dec_ins && (dec_status == ST_OK);
	assign sts.go_del   = dec_del && (dec_status == ST_OK);
	assign sts.ins_more = (idx_q > tgt_q);
	assign sts.del_more = (idx_p1_wide < {1'b0, count_q});
	assign sts.rsp_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		if (cmd.rd_ins) begin
			raddr = idx_m1[AW-1:0];
		end else if (cmd.rd_del_next) begin
			raddr = idx_p1[AW-1:0];
		end else begin
			raddr = tgt_q[AW-1:0];
		end
	end

	assign we    = cmd.wr_shift || cmd.wr_put;
	assign waddr = cmd.wr_put ? tgt_q[AW-1:0] : idx_q[AW-1:0];
	assign wdata = cmd.wr_put ? value_q : rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// request fields and removed value are payload only
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= action;
			pos_q    <= position;
			value_q  <= value;
		end
		if (cmd.decode) begin
			removed_q <= '0;
		end else if (cmd.del_cap) begin
			removed_q <= rd_q;
		end
		if (cmd.load_rsp) begin
			rsp_removed_q <= removed_q;
			rsp_status_q  <= status_q;
			rsp_count_q   <= cnt_ext[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			tgt_q       <= '0;
			status_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.decode) begin
				status_q <= dec_status;
				tgt_q    <= dec_tgt;
				// insert moves entries down from the top, delete from the target up
				idx_q    <= dec_ins ? count_q : dec_tgt;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign removed_value = rsp_removed_q;
	assign status        = rsp_status_q;
	assign element_count = rsp_count_q;

endmodule

### rtl/positional_list_engine_core.sv
// A rejected or ignored request goes from decode to finish; an insert or a delete
// first shifts the entries one at a time, and the result may then wait in the
// output register for rsp_ready.
// Throughput: one request at a time; each moved entry needs a read and a
// write on the one-read, one-write entry memory, so shifts set the rate.
// Reset clears the fill count and output valid; entries hold no reset.
`timescale 1ns / 1ps

module positional_list_engine_core #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [2:0]         action,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic signed [31:0] removed_value,
	output logic [1:0]         status,
	output logic [6:0]         element_count
);
	import ple_pkg::*;

	ple_cmd_t cmd;
	ple_sts_t sts;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ple_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (action),
		.position      (position),
		.value         (value),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.removed_value (removed_value),
		.status        (status),
		.element_count (element_count)
	);

endmodule

### test/ple_list_checker.sv
// Checker for positional_list_engine_core: watches both handshake channels,
// predicts each result from its own copy of the list and compares them.
// Depends on ple_pkg for the action and status codes.
`timescale 1ns / 1ps

module ple_list_checker #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  logic [2:0]         action,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  logic signed [31:0] removed_value,
	input  logic [1:0]         status,
	input  logic [6:0]         element_count,
	output int                 mismatches,
	output int                 outstanding,
	output logic [6:0]         list_len
);

	import ple_pkg::*;

	typedef struct {
		logic signed [31:0] removed;
		status_t            st;
		logic [6:0]         count;
	} list_result_t;

	logic signed [31:0] cells [0:CAPACITY-1];
	int                 held = 0;
	list_result_t       pending_results [$];

	int         fail_tally = 0;
	int         backlog = 0;
	logic [6:0] held_seen = 7'd0;

	assign mismatches  = fail_tally;
	assign outstanding = backlog;
	assign list_len    = held_seen;

	// Apply one request to the list copy and queue the result it yields.
	task automatic apply_to_list(input logic [2:0] act, input logic [6:0] pos,
			input logic signed [31:0] val);
		list_result_t r;
		int           slot;
		int           i;
		logic         do_put;
		logic         do_take;
		r.removed = '0;
		r.st      = ST_OK;
		slot      = 0;
		do_put    = 1'b0;
		do_take   = 1'b0;
		case (act)
			ACT_INS_FRONT: begin
				do_put = 1'b1;
			end
			ACT_INS_POS: begin
				if (pos > held)
					r.st = ST_BAD_POS;
				else begin
					do_put = 1'b1;
					slot   = pos;
				end
			end
			ACT_INS_BACK: begin
				do_put = 1'b1;
				slot   = held;
			end
			ACT_DEL_FRONT: begin
				if (held == 0)
					r.st = ST_EMPTY;
				else
					do_take = 1'b1;
			end
			ACT_DEL_POS: begin
				if (pos >= held)
					r.st = ST_BAD_POS;
				else begin
					do_take = 1'b1;
					slot    = pos;
				end
			end
			ACT_DEL_BACK: begin
				if (held == 0)
					r.st = ST_EMPTY;
				else begin
					do_take = 1'b1;
					slot    = held - 1;
				end
			end
			default: ;
		endcase
		// position check comes first, then the full check
		if (do_put) begin
			if (held >= CAPACITY)
				r.st = ST_FULL;
			else begin
				for (i = held; i > slot; i--)
					cells[i] = cells[i-1];
				cells[slot] = val;
				held++;
			end
		end
		if (do_take) begin
			r.removed = cells[slot];
			for (i = slot; i < held - 1; i++)
				cells[i] = cells[i+1];
			held--;
		end
		r.count = 7'(held);
		pending_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			held = 0;
			pending_results.delete();
		end else begin
			if (req_valid && req_ready)
				apply_to_list(action, position, value);
			if (rsp_valid && rsp_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result transaction: removed %0d status %0d count %0d",
						$time, removed_value, status, element_count);
					fail_tally++;
				end else begin
					want = pending_results.pop_front();
					if (removed_value !== want.removed) begin
						$display("%0t: removed_value expected %0d actual %0d",
							$time, want.removed, removed_value);
						fail_tally++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, status);
						fail_tally++;
					end
					if (element_count !== want.count) begin
						$display("%0t: element_count expected %0d actual %0d",
							$time, want.count, element_count);
						fail_tally++;
					end
				end
			end
		end
		backlog   <= pending_results.size();
		held_seen <= 7'(held);
	end

endmodule

### test/tb_positional_list_engine_core.sv
// Testbench top for positional_list_engine_core: drives requests in bursts,
// stalls the result channel and gives the verdict from ple_list_checker.
// Depends on ple_pkg, positional_list_engine_core and ple_list_checker.
`timescale 1ns / 1ps

module tb_positional_list_engine_core;

	import ple_pkg::*;

	localparam int LIST_DEPTH = CAPACITY_DEF;
	localparam int RAND_ITEMS = 930;

	// codes the block decodes to no operation
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	// request mix modes
	localparam int MIX_GROW   = 0;
	localparam int MIX_SHRINK = 1;
	localparam int MIX_EVEN   = 2;

	// result channel stall modes
	localparam int RX_OPEN   = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_SPARSE = 2;
	localparam int RX_HOLD   = 3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic [2:0]         action = ACT_INS_FRONT;
	logic [6:0]         position = 7'd0;
	logic signed [31:0] value = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic signed [31:0] removed_value;
	logic [1:0]         status;
	logic [6:0]         element_count;

	int         mismatch_total;
	int         outstanding;
	logic [6:0] list_len;

	int stall_mode = RX_OPEN;
	int stall_left = 0;

	positional_list_engine_core #(
		.CAPACITY(LIST_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.position     (position),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.removed_value(removed_value),
		.status       (status),
		.element_count(element_count)
	);

	ple_list_checker #(
		.CAPACITY(LIST_DEPTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.action       (action),
		.position     (position),
		.value        (value),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.removed_value(removed_value),
		.status       (status),
		.element_count(element_count),
		.mismatches   (mismatch_total),
		.outstanding  (outstanding),
		.list_len     (list_len)
	);

	always #5 clk = ~clk;

	// Hold the request until it is taken; call at a rising edge.
	task automatic push_request(input logic [2:0] act, input logic [6:0] pos,
			input logic signed [31:0] val);
		req_valid <= 1'b1;
		action    <= act;
		position  <= pos;
		value     <= val;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(RX_OPEN, RX_HOLD);
			stall_left <= $urandom_range(10, 30);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			RX_OPEN:   rsp_ready <= 1'b1;
			RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
			default:   rsp_ready <= 1'b0;
		endcase
	end

	initial begin
		action_t     ins_codes [4];
		action_t     del_codes [4];
		logic [31:0] corner_vals [4];
		logic [2:0]  act;
		logic [6:0]  pos;
		logic [31:0] val;
		logic        is_ins;
		int          mix;
		int          mix_left;
		int          insert_pct;
		int          burst;
		int          gap;
		int          sent;
		int          sel;

		ins_codes   = '{ACT_INS_FRONT, ACT_INS_POS, ACT_INS_POS, ACT_INS_BACK};
		del_codes   = '{ACT_DEL_FRONT, ACT_DEL_POS, ACT_DEL_POS, ACT_DEL_BACK};
		corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, out-of-range positions, spare codes, middle shifts
		push_request(ACT_DEL_FRONT, 7'd0, 32'sd0);
		push_request(ACT_DEL_BACK, 7'd0, 32'sd0);
		push_request(ACT_DEL_POS, 7'd0, 32'sd0);
		push_request(ACT_INS_POS, 7'd1, 32'sd1);
		push_request(ACT_INS_POS, 7'd0, 32'h7FFF_FFFF);
		push_request(ACT_INS_FRONT, 7'd127, 32'h8000_0000);
		push_request(ACT_INS_BACK, 7'd0, -32'sd1);
		push_request(ACT_INS_POS, 7'd3, 32'sd0);
		push_request(ACT_INS_POS, 7'd2, 32'h5555_5555);
		push_request(ACT_INS_POS, 7'd127, 32'h2AAA_AAAA);
		push_request(ACT_SPARE_LO, 7'd127, -32'sd1);
		push_request(ACT_SPARE_HI, 7'd0, 32'sd0);
		push_request(ACT_DEL_POS, 7'd5, 32'sd0);
		push_request(ACT_DEL_POS, 7'd127, 32'sd0);
		push_request(ACT_DEL_POS, 7'd2, 32'sd0);
		push_request(ACT_DEL_FRONT, 7'd0, 32'sd0);
		push_request(ACT_DEL_BACK, 7'd0, 32'sd0);
		push_request(ACT_DEL_POS, 7'd0, 32'sd0);
		push_request(ACT_DEL_BACK, 7'd0, 32'sd0);
		push_request(ACT_DEL_POS, 7'd0, 32'sd0);

		// open with a long growth phase so the full list is reached early
		mix      = MIX_GROW;
		mix_left = 120;
		sent     = 0;
		while (sent < RAND_ITEMS) begin
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
				: $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < RAND_ITEMS; k++) begin
				if (mix_left == 0) begin
					mix      = $urandom_range(MIX_GROW, MIX_EVEN);
					mix_left = $urandom_range(30, 120);
				end
				mix_left--;
				insert_pct = (mix == MIX_GROW) ? 85 : (mix == MIX_SHRINK) ? 15 : 50;
				is_ins = ($urandom_range(0, 99) < insert_pct);
				if ($urandom_range(0, 99) < 3)
					act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
				else if (is_ins)
					act = ins_codes[2'($urandom_range(0, 3))];
				else
					act = del_codes[2'($urandom_range(0, 3))];
				// mostly legal positions, some at the count, some anywhere
				sel = $urandom_range(0, 19);
				if (sel < 14) begin
					if (is_ins)
						pos = 7'($urandom_range(0, list_len));
					else
						pos = (list_len == 0) ? 7'd0
							: 7'($urandom_range(0, list_len - 1));
				end else if (sel < 16)
					pos = list_len;
				else
					pos = 7'($urandom_range(0, 127));
				val = ($urandom_range(0, 9) == 0) ? corner_vals[2'($urandom_range(0, 3))]
					: $urandom();
				push_request(act, pos, val);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_total == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
